/* design/bmfa_pkg.sv */
package bmfa_pkg;

	localparam int ALPHA_FRAC_BITS_DEF = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int TIME_W     = 32;
	localparam int LEVEL_W    = 16;
	localparam int RC_W       = 20;

	localparam logic [15:0] LOW_VOLT_THR_RST  = 16'd10000;
	localparam logic [15:0] CRIT_VOLT_THR_RST = 16'd9500;
	localparam logic [15:0] MAX_CURR_THR_RST  = 16'd10000;
	localparam logic [31:0] LOW_VOLT_TO_RST   = 32'd5000;
	localparam logic [31:0] CRIT_VOLT_TO_RST  = 32'd5000;
	localparam logic [31:0] MAX_CURR_TO_RST   = 32'd500;
	// 1 / (2 * pi * 10 Hz) expressed in microseconds.
	localparam logic [19:0] FILTER_RC_RST     = 20'd15915;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW_VOLT_THR  = 3'd0,
		REG_CRIT_VOLT_THR = 3'd1,
		REG_MAX_CURR_THR  = 3'd2,
		REG_LOW_VOLT_TO   = 3'd3,
		REG_CRIT_VOLT_TO  = 3'd4,
		REG_MAX_CURR_TO   = 3'd5,
		REG_VOLT_RC       = 3'd6,
		REG_CURR_RC       = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		STATUS_OK          = 2'd0,
		STATUS_LOW         = 2'd1,
		STATUS_CRITICAL    = 2'd2,
		STATUS_OVERCURRENT = 2'd3
	} status_t;

endpackage

/* design/battery_monitor_filter_alarm_core.sv */
// Battery monitor: low-pass filters on voltage and current with three persistence alarms.
// Input channel: in_valid/in_stall carries time_ms, volt_sample and current_sample. A beat
// is taken only while the sequencer is idle; in_stall is high while an item is at work.
// Output channel: out_valid/out_stall carries alarm_status, filtered_volt and
// filtered_current, one beat per input beat, held in an output register.
// The first item after reset seeds the filters directly and skips the divider. Every
// later item passes through the restoring divider that forms each filter coefficient
// one quotient bit per cycle; it is shared by the voltage and current channels in turn,
// as is the one multiplier.
// A new item may be accepted while the previous result still waits in the output
// register. If the receiver stalls, the next result waits in its final step and the input
// stays stalled until the output register frees up.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the clock edge and
// are to be issued only while no item is in flight.
// Reset restores the default thresholds, timeouts and time constants, clears the filter
// levels and alarm arming, and the next item seeds the filters again.
module battery_monitor_filter_alarm_core #(
	parameter int ALPHA_FRAC_BITS = bmfa_pkg::ALPHA_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bmfa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bmfa_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [bmfa_pkg::TIME_W-1:0]      time_ms,
	input  logic [bmfa_pkg::LEVEL_W-1:0]     volt_sample,
	input  logic [bmfa_pkg::LEVEL_W-1:0]     current_sample,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [1:0]                       alarm_status,
	output logic [bmfa_pkg::LEVEL_W-1:0]     filtered_volt,
	output logic [bmfa_pkg::LEVEL_W-1:0]     filtered_current
);
	import bmfa_pkg::*;

	localparam int F    = ALPHA_FRAC_BITS;
	localparam int QW   = F + 1;
	localparam int AW   = F + 2;
	localparam int CW   = $clog2(F + 1);
	localparam int PW   = AW + LEVEL_W + 1;
	localparam int DTW  = TIME_W + 10;
	localparam int DENW = DTW + 1;
	localparam logic [AW-1:0] ONE     = AW'(1) << F;
	localparam logic [CW-1:0] CNT_TOP = CW'(F);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_DT    = 7'b0000010,
		ST_DEN   = 7'b0000100,
		ST_DIV   = 7'b0001000,
		ST_MUL   = 7'b0010000,
		ST_ACC   = 7'b0100000,
		ST_ALARM = 7'b1000000
	} state_t;

	state_t state_q;

	logic [15:0] low_thr_q, crit_thr_q, curr_thr_q;
	logic [31:0] low_to_q, crit_to_q, curr_to_q;
	logic [RC_W-1:0] volt_rc_q, curr_rc_q;

	logic [LEVEL_W-1:0] volt_level_q, current_level_q;
	logic [TIME_W-1:0]  prev_time_q;
	logic               seeded_q;
	logic               low_armed_q, crit_armed_q, oc_armed_q;
	logic [TIME_W-1:0]  low_start_q, crit_start_q, oc_start_q;

	logic [TIME_W-1:0]  time_q;
	logic [LEVEL_W-1:0] vs_q, cs_q;
	logic               sel_q;
	logic [DTW-1:0]     dt_us_q;
	logic [DENW-1:0]    den_q;
	logic [DENW-1:0]    rem_q;
	logic [QW-1:0]      quo_q;
	logic [CW-1:0]      cnt_q;
	logic signed [PW-1:0] prod_q;

	logic               out_valid_q;
	status_t            status_q;
	logic [LEVEL_W-1:0] fv_q, fc_q;

	// Datapath wires.
	logic [TIME_W-1:0]    dt_w;
	logic [DTW-1:0]       dt_us_w;
	logic [RC_W-1:0]      rc_sel;
	logic [LEVEL_W-1:0]   lvl_sel, smp_sel;
	logic [DENW:0]        trial_w, diff_den_w;
	logic                 ge_w;
	logic [AW-1:0]        comp_w, alpha_w;
	logic signed [LEVEL_W:0]   delta_in_w;
	logic signed [PW-1:0]      shift_w;
	logic signed [LEVEL_W+1:0] sum_w;
	logic [LEVEL_W-1:0]   new_level_w;
	logic                 low_cond, crit_cond, oc_cond;
	logic                 low_fire, crit_fire, oc_fire;
	status_t              status_w;
	logic                 out_free;

	always_comb begin
		dt_w    = time_q - prev_time_q;
		// dt * 1000 as 1024 - 32 + 8.
		dt_us_w = {dt_w, 10'b0} - DTW'({dt_w, 5'b0}) + DTW'({dt_w, 3'b0});

		rc_sel  = sel_q ? curr_rc_q : volt_rc_q;
		lvl_sel = sel_q ? current_level_q : volt_level_q;
		smp_sel = sel_q ? cs_q : vs_q;

		// One restoring step: the partial remainder is doubled except on the integer bit.
		trial_w    = (cnt_q == CNT_TOP) ? {1'b0, rem_q} : {rem_q, 1'b0};
		ge_w       = trial_w >= {1'b0, den_q};
		diff_den_w = trial_w - {1'b0, den_q};

		// ceil(rc * one / den) is the quotient plus one when anything is left over.
		comp_w  = {1'b0, quo_q} + AW'(rem_q != '0);
		alpha_w = (rc_sel == '0) ? ONE : ONE - comp_w;

		delta_in_w  = $signed({1'b0, smp_sel}) - $signed({1'b0, lvl_sel});
		shift_w     = prod_q >>> F;
		sum_w       = $signed({2'b00, lvl_sel}) + (LEVEL_W+2)'(shift_w);
		new_level_w = sum_w[LEVEL_W-1:0];

		low_cond  = volt_level_q < low_thr_q;
		crit_cond = volt_level_q < crit_thr_q;
		oc_cond   = current_level_q > curr_thr_q;
		low_fire  = low_cond && low_armed_q && ((time_q - low_start_q) > low_to_q);
		crit_fire = crit_cond && crit_armed_q && ((time_q - crit_start_q) > crit_to_q);
		oc_fire   = oc_cond && oc_armed_q && ((time_q - oc_start_q) > curr_to_q);

		if (oc_fire) begin
			status_w = STATUS_OVERCURRENT;
		end else if (crit_fire) begin
			status_w = STATUS_CRITICAL;
		end else if (low_fire) begin
			status_w = STATUS_LOW;
		end else begin
			status_w = STATUS_OK;
		end

		out_free = !out_valid_q || !out_stall;
	end

	assign in_stall         = (state_q != ST_IDLE);
	assign out_valid        = out_valid_q;
	assign alarm_status     = status_q;
	assign filtered_volt    = fv_q;
	assign filtered_current = fc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_thr_q  <= LOW_VOLT_THR_RST;
			crit_thr_q <= CRIT_VOLT_THR_RST;
			curr_thr_q <= MAX_CURR_THR_RST;
			low_to_q   <= LOW_VOLT_TO_RST;
			crit_to_q  <= CRIT_VOLT_TO_RST;
			curr_to_q  <= MAX_CURR_TO_RST;
			volt_rc_q  <= FILTER_RC_RST;
			curr_rc_q  <= FILTER_RC_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				REG_LOW_VOLT_THR:  low_thr_q  <= cfg_data[15:0];
				REG_CRIT_VOLT_THR: crit_thr_q <= cfg_data[15:0];
				REG_MAX_CURR_THR:  curr_thr_q <= cfg_data[15:0];
				REG_LOW_VOLT_TO:   low_to_q   <= cfg_data;
				REG_CRIT_VOLT_TO:  crit_to_q  <= cfg_data;
				REG_MAX_CURR_TO:   curr_to_q  <= cfg_data;
				REG_VOLT_RC:       volt_rc_q  <= cfg_data[RC_W-1:0];
				REG_CURR_RC:       curr_rc_q  <= cfg_data[RC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			out_valid_q     <= 1'b0;
			seeded_q        <= 1'b0;
			low_armed_q     <= 1'b0;
			crit_armed_q    <= 1'b0;
			oc_armed_q      <= 1'b0;
			volt_level_q    <= '0;
			current_level_q <= '0;
			prev_time_q     <= '0;
			low_start_q     <= '0;
			crit_start_q    <= '0;
			oc_start_q      <= '0;
			sel_q           <= 1'b0;
			cnt_q           <= '0;
		end else begin
			// A new beat may replace the one leaving in the same cycle.
			if (state_q == ST_ALARM && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						time_q <= time_ms;
						vs_q   <= volt_sample;
						cs_q   <= current_sample;
						sel_q  <= 1'b0;
						if (!seeded_q) begin
							volt_level_q    <= volt_sample;
							current_level_q <= current_sample;
							seeded_q        <= 1'b1;
							state_q         <= ST_ALARM;
						end else begin
							state_q <= ST_DT;
						end
					end
				end
				ST_DT: begin
					dt_us_q <= dt_us_w;
					state_q <= ST_DEN;
				end
				ST_DEN: begin
					den_q   <= DENW'(dt_us_q) + DENW'(rc_sel);
					rem_q   <= DENW'(rc_sel);
					quo_q   <= '0;
					cnt_q   <= CNT_TOP;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= ge_w ? diff_den_w[DENW-1:0] : trial_w[DENW-1:0];
					quo_q <= {quo_q[QW-2:0], ge_w};
					if (cnt_q == '0) begin
						state_q <= ST_MUL;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				ST_MUL: begin
					prod_q  <= $signed(alpha_w) * delta_in_w;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (sel_q) begin
						current_level_q <= new_level_w;
						state_q         <= ST_ALARM;
					end else begin
						volt_level_q <= new_level_w;
						sel_q        <= 1'b1;
						state_q      <= ST_DEN;
					end
				end
				ST_ALARM: begin
					if (out_free) begin
						prev_time_q  <= time_q;
						low_armed_q  <= low_cond;
						crit_armed_q <= crit_cond;
						oc_armed_q   <= oc_cond;
						if (low_cond && !low_armed_q) begin
							low_start_q <= time_q;
						end
						if (crit_cond && !crit_armed_q) begin
							crit_start_q <= time_q;
						end
						if (oc_cond && !oc_armed_q) begin
							oc_start_q <= time_q;
						end
						status_q    <= status_w;
						fv_q        <= volt_level_q;
						fc_q        <= current_level_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_result_from_alarm_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_ALARM))
		else $error("result appeared without passing the alarm step");

	a_div_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q <= CNT_TOP)
		else $error("divider step count out of range");

	// With a zero time constant the divider output is not used.
	a_coeff_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL && rc_sel != '0 |-> comp_w <= ONE)
		else $error("filter coefficient complement exceeds one");

	a_seeded_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		$past(seeded_q) |-> seeded_q)
		else $error("seeded flag dropped without reset");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall && state_q == ST_ALARM |=> $stable(fv_q) && $stable(fc_q))
		else $error("pending result overwritten");
`endif

endmodule
